// ----- rtl/gss_pkg.sv -----
`timescale 1ns / 1ps

package gss_pkg;

  localparam int TAP_BITS       = 16;
  localparam int GAIN_BITS      = 16;
  localparam int OUT_BITS       = 16;
  localparam int TAP_GROUPS     = 6;
  localparam int TAPS_PER_GROUP = 4;
  localparam int TAP_TOTAL      = TAP_GROUPS * TAPS_PER_GROUP;
  localparam int TAP_IDX_BITS   = 5;
  localparam int TAP_COUNT_BITS = 5;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int FRAC_SHIFT     = 24;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd256;

  localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_A     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_F     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT  = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_GAIN = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ROTATE,
    ST_EMIT,
    ST_ZERO
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic append;
  } cell_ctl_t;

  typedef struct packed {
    logic start;
    logic mac_en;
    logic fin;
  } mac_ctl_t;

  typedef struct packed {
    logic done;
  } mac_sts_t;

endpackage

// ----- rtl/gss_sample_if.sv -----
`timescale 1ns / 1ps

interface gss_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

// ----- rtl/gss_result_if.sv -----
`timescale 1ns / 1ps

interface gss_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] smoothed;
  logic        last_out;

  modport source (output valid, output smoothed, output last_out, input ready);
  modport sink (input valid, input smoothed, input last_out, output ready);
endinterface

// ----- rtl/gss_cell.sv -----
`timescale 1ns / 1ps

module gss_cell
  import gss_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_BITS    = 5,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctl_t              ctl,
  input  logic [CNT_BITS-1:0]    fill,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] right,
  output logic [SAMPLE_BITS-1:0] value
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      value <= '0;
    end else if (ctl.shift) begin
      value <= right;
    end else if (ctl.append && (fill == CNT_BITS'(INDEX))) begin
      value <= sample;
    end
  end

endmodule

// ----- rtl/gss_mac.sv -----
`timescale 1ns / 1ps

module gss_mac
  import gss_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_TAPS    = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mac_ctl_t               ctl,
  input  logic [TAP_BITS-1:0]    tap,
  input  logic [SAMPLE_BITS-1:0] head,
  input  logic [GAIN_BITS-1:0]   gain,
  output mac_sts_t               sts,
  output logic [OUT_BITS-1:0]    result
);

  localparam int PROD_BITS = TAP_BITS + SAMPLE_BITS;
  localparam int ACC_BITS  = PROD_BITS + $clog2(MAX_TAPS + 1);
  localparam int SC_BITS   = ACC_BITS + GAIN_BITS;
  localparam int HI_BITS   = SC_BITS - FRAC_SHIFT;
  localparam logic [HI_BITS-1:0] SAMP_MAX = HI_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [PROD_BITS-1:0] prod;
  logic                 prod_en;
  logic [ACC_BITS-1:0]  acc;
  logic [SC_BITS-1:0]   scaled;
  logic                 fin_p;
  logic                 fin_a;
  logic [HI_BITS-1:0]   hi;
  logic [HI_BITS-1:0]   sat;

  always_ff @(posedge clk) begin
    prod <= tap * head;
    if (ctl.start) begin
      acc <= '0;
    end else if (prod_en) begin
      acc <= acc + ACC_BITS'(prod);
    end
    scaled <= SC_BITS'(acc) * SC_BITS'(gain);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      prod_en  <= 1'b0;
      fin_p    <= 1'b0;
      fin_a    <= 1'b0;
      sts.done <= 1'b0;
    end else begin
      prod_en <= ctl.mac_en;
      fin_p   <= ctl.fin;
      fin_a   <= fin_p;
      if (fin_a) begin
        sts.done <= 1'b1;
      end
    end
  end

  assign hi     = scaled[SC_BITS-1:FRAC_SHIFT];
  assign sat    = (hi > SAMP_MAX) ? SAMP_MAX : hi;
  assign result = OUT_BITS'(sat);

endmodule

// ----- rtl/gaussian_spectrum_smoother.sv -----
`timescale 1ns / 1ps

// Gaussian spectrum smoother: forward-looking FIR over a streamed spectrum.
// Input channel "samples" carries one spectrum count per item plus a last
// flag on the final channel. Output channel "results" carries one smoothed
// count per item; last_out marks the final result of a spectrum. Both use
// valid/ready and move an item when both are high.
// Taps, tap count and gain are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce. A write takes effect on the next edge. Samples
// sit in a row of MAX_TAPS cells. Each result rotates the row once through
// a single multiply-accumulate unit. The block takes no new item until the
// last one has yielded every result it completes, and a final item flushes
// every pending channel. A result waits in the output register while the
// receiver stalls. Items are still taken meanwhile; the next result holds
// in the accumulator, with the row frozen, until the register frees. Reset
// empties the row, clears the taps and tap count, and sets the gain to 1.0.
module gaussian_spectrum_smoother
  import gss_pkg::*;
#(
  parameter int MAX_TAPS    = 24,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  gss_sample_if.sink               samples,
  gss_result_if.source             results
);

  localparam int CNT_BITS = $clog2(MAX_TAPS + 1);
  localparam int IDX_BITS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  logic [CFG_DATA_BITS-1:0]  tap_regs [TAP_GROUPS];
  logic [TAP_COUNT_BITS-1:0] tap_count;
  logic [GAIN_BITS-1:0]      count_gain;

  state_t state;
  state_t state_next;

  logic [CNT_BITS-1:0] fill;
  logic [IDX_BITS-1:0] cnt;
  logic                last_flag;
  logic [CNT_BITS-1:0] k_act;

  logic                   accept;
  logic                   out_free;
  logic                   load_out;
  logic                   load_zero;
  logic                   wrap;
  cell_ctl_t              cell_ctl;
  mac_ctl_t               mac_ctl;
  mac_sts_t               mac_sts;
  logic [OUT_BITS-1:0]    mac_result;
  logic [TAP_BITS-1:0]    taps [TAP_TOTAL];
  logic [TAP_BITS-1:0]    tap_sel;
  logic [SAMPLE_BITS-1:0] cell_val [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < TAP_GROUPS; g++) begin
        tap_regs[g] <= '0;
      end
      tap_count  <= '0;
      count_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        [REG_TAPS_A:REG_TAPS_F]: tap_regs[cfg_index] <= cfg_data;
        REG_TAP_COUNT:           tap_count <= cfg_data[TAP_COUNT_BITS-1:0];
        REG_COUNT_GAIN:          count_gain <= cfg_data[GAIN_BITS-1:0];
        default:                 ;
      endcase
    end
  end

  assign k_act = (32'(tap_count) > MAX_TAPS) ? CNT_BITS'(MAX_TAPS) : CNT_BITS'(tap_count);

  always_comb begin
    for (int g = 0; g < TAP_GROUPS; g++) begin
      for (int t = 0; t < TAPS_PER_GROUP; t++) begin
        taps[g*TAPS_PER_GROUP + t] = tap_regs[g][t*TAP_BITS +: TAP_BITS];
      end
    end
  end

  assign tap_sel = (32'(cnt) < TAP_TOTAL) ? taps[TAP_IDX_BITS'(cnt)] : '0;

  assign accept   = samples.valid && samples.ready;
  assign out_free = !results.valid || results.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          state_next = (k_act == '0) ? ST_ZERO : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((fill != '0) && ((fill >= k_act) || last_flag)) begin
          state_next = ST_ROTATE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ROTATE: begin
        if (cnt == IDX_BITS'(MAX_TAPS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (mac_sts.done && out_free) begin
          state_next = ST_CHECK;
        end
      end
      ST_ZERO: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    samples.ready   = (state == ST_IDLE);
    wrap            = (state == ST_ROTATE);
    load_out        = (state == ST_EMIT) && mac_sts.done && out_free;
    load_zero       = (state == ST_ZERO) && out_free;
    cell_ctl.clear  = accept && (k_act == '0);
    cell_ctl.append = accept && (k_act != '0);
    cell_ctl.shift  = wrap || load_out;
    mac_ctl.start   = (state == ST_CHECK);
    mac_ctl.mac_en  = wrap && (CNT_BITS'(cnt) < k_act);
    mac_ctl.fin     = wrap && (cnt == IDX_BITS'(MAX_TAPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      cnt       <= '0;
      last_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (cell_ctl.clear) begin
        fill <= '0;
      end else if (cell_ctl.append) begin
        fill <= fill + 1'b1;
      end else if (load_out) begin
        fill <= fill - 1'b1;
      end
      if (accept) begin
        last_flag <= samples.last;
      end
      if (mac_ctl.start) begin
        cnt <= '0;
      end else if (wrap) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    logic [SAMPLE_BITS-1:0] right;
    if (j == MAX_TAPS - 1) begin : g_tail
      assign right = wrap ? cell_val[0] : '0;
    end else begin : g_body
      assign right = cell_val[j+1];
    end
    gss_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_BITS    (CNT_BITS),
      .INDEX       (j)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (cell_ctl),
      .fill   (fill),
      .sample (samples.sample),
      .right  (right),
      .value  (cell_val[j])
    );
  end

  gss_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TAPS    (MAX_TAPS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .tap    (tap_sel),
    .head   (cell_val[0]),
    .gain   (count_gain),
    .sts    (mac_sts),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load_out || load_zero) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      results.smoothed <= mac_result;
      results.last_out <= last_flag && (fill == CNT_BITS'(1));
    end else if (load_zero) begin
      results.smoothed <= '0;
      results.last_out <= last_flag;
    end
  end

endmodule

// ----- rtl/gss_checker.sv -----
`timescale 1ns / 1ps

module gss_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] smoothed,
  input logic        last_out
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result shown right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while the previous one is still in work");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("stalled result dropped");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(smoothed) && $stable(last_out))
    else $error("stalled result changed");

endmodule

bind gaussian_spectrum_smoother gss_checker u_gss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .smoothed  (results.smoothed),
  .last_out  (results.last_out)
);
